// ===== rtl/wma_pkg.sv =====
`default_nettype none

package wma_pkg;

    localparam int SAMPLE_BITS     = 32;
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SIZE_W          = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FILL   = 1'b1;

    typedef struct packed {
        logic                          opcode;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } t_wma_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [SIZE_W-1:0]             samples_held;
    } t_wma_out;

endpackage

`default_nettype wire

// ===== rtl/wma_window_store.sv =====
`default_nettype none

module wma_window_store
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_wr_en,
    input  wire logic [IDX_W-1:0]       i_wr_addr,
    input  wire logic [SAMPLE_BITS-1:0] i_wr_data,
    input  wire logic [IDX_W-1:0]       i_rd_addr,
    output logic      [SAMPLE_BITS-1:0] o_rd_data
);

    logic [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/wma_divider.sv =====
`default_nettype none

module wma_divider
    import wma_pkg::*;
#(
    parameter int SUM_W = SAMPLE_BITS + 7,
    parameter int CNT_W = 7
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic        [CNT_W-1:0] i_divisor,
    output logic                         o_done,
    output logic signed      [SUM_W-1:0] o_quotient
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_q;
    logic [CNT_W:0]    r_rem;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;
    logic [CNT_W:0]    rem_nx;
    logic [SUM_W-1:0]  dividend_abs;

    assign dividend_abs = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;

    // One restoring step per cycle: shift the next dividend bit into the remainder.
    assign rem_sh = {r_rem[CNT_W-1:0], r_q[SUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_div};
    assign rem_nx = rem_ge ? (rem_sh - {1'b0, r_div}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ITER_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= dividend_abs;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], rem_ge};
            r_rem <= rem_nx;
        end
    end

    // Magnitude division followed by a sign fix gives truncation toward zero.
    assign o_quotient = r_neg ? $signed(~r_q + 1'b1) : $signed(r_q);
    assign o_done     = r_done;

endmodule

`default_nettype wire

// ===== rtl/window_moving_average_unit.sv =====
// Sliding-window average of signed Q16.16 samples.
// Input channel (i_valid/o_ready, i_data): opcode 0 adds a sample and yields one
// result item; opcode 1 loads the sample value into every window entry and yields
// nothing. Output channel (o_valid/i_ready, o_data): average truncated toward
// zero and the number of samples held.
// The block takes one item at a time; o_ready is high only while it is idle.
// A sample item passes through the read, subtract, add, divider start and divide
// states and then the output state; the bit-serial divider runs one quotient bit
// per cycle. o_ready comes back together with o_valid, so the next item is taken
// only after the last result has reached the output register. A fill item keeps
// o_ready low while it writes the window entries one by one, since the window
// store has one write port. With a window size of 0 a sample goes straight to the
// output state without division, and a fill item is dropped.
// The user must write the window size register through i_cfg_wr_en/i_cfg_wr_data
// only while the block is idle; the block does not enforce this. A write clears
// the position, count and running sum. Reset restores a window size of 16 with an
// empty window; store contents are kept and are never used before being written.
// A stalled receiver holds the result in the output register; the block accepts
// the next item meanwhile but waits to deliver until that register is free.
`default_nettype none

module window_moving_average_unit
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_wma_in           i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_wma_out               o_data,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [SIZE_W-1:0] i_cfg_wr_data
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int EXT_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FILL   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SUB    = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_PUSH   = 3'd7;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [SIZE_W-1:0]             r_size;
    logic [IDX_W-1:0]              r_wp;
    logic [CNT_W-1:0]              r_held;
    logic [CNT_W-1:0]              r_fidx;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_avg;
    logic                          r_out_valid;
    t_wma_out                      r_out;

    logic [CNT_W-1:0]              win_n;
    logic [EXT_W-1:0]              size_ext;
    logic [CNT_W-1:0]              wp_ext;
    logic [CNT_W-1:0]              wp_inc;
    logic [IDX_W-1:0]              wp_eff;
    logic [CNT_W-1:0]              held_eff;
    logic                          in_acc;
    logic                          out_free;

    logic                          alu_sub;
    logic signed [SUM_W-1:0]       alu_b;
    logic signed [SUM_W-1:0]       alu_y;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic                          div_done;
    logic signed [SUM_W-1:0]       div_q;

    assign size_ext = EXT_W'(r_size);
    assign win_n    = (size_ext > EXT_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(size_ext);

    assign wp_ext   = CNT_W'(r_wp);
    assign wp_eff   = (wp_ext >= win_n) ? '0 : r_wp;
    assign held_eff = (r_held > win_n) ? win_n : r_held;
    assign wp_inc   = wp_ext + 1'b1;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Shared sum adder: subtracts the oldest entry, adds the new sample or fill value.
    assign alu_sub = (r_state == S_SUB);
    assign alu_b   = alu_sub
                   ? {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data}
                   : {{(SUM_W-SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
    assign alu_y   = alu_sub ? (r_sum - alu_b) : (r_sum + alu_b);

    assign mem_we    = (r_state == S_FILL) || (r_state == S_ADD);
    assign mem_waddr = (r_state == S_FILL) ? r_fidx[IDX_W-1:0] : r_wp;

    wma_window_store #(
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (r_sample),
        .i_rd_addr (r_wp),
        .o_rd_data (rd_data)
    );

    wma_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_sum),
        .i_divisor  (r_held),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (win_n == '0) begin
                        n_state = (i_data.opcode == OP_FILL) ? S_IDLE : S_PUSH;
                    end else begin
                        n_state = (i_data.opcode == OP_FILL) ? S_FILL : S_READ;
                    end
                end
            end
            S_FILL: begin
                if (r_fidx == win_n - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            S_READ:   n_state = S_SUB;
            S_SUB:    n_state = S_ADD;
            S_ADD:    n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_RESET;
            r_wp        <= '0;
            r_held      <= '0;
            r_sum       <= '0;
            r_fidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if ((r_state == S_PUSH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sample <= i_data.sample_value;
                        r_avg    <= i_data.sample_value;
                        r_fidx   <= '0;
                        if (i_data.opcode == OP_FILL) begin
                            r_sum <= '0;
                        end else begin
                            r_wp   <= wp_eff;
                            r_held <= held_eff;
                        end
                    end
                end
                S_FILL: begin
                    r_sum  <= alu_y;
                    r_fidx <= r_fidx + 1'b1;
                    if (r_fidx == win_n - 1'b1) begin
                        r_held <= win_n;
                        r_wp   <= '0;
                    end
                end
                S_SUB: begin
                    // A full window drops its oldest entry; otherwise the count grows.
                    if (r_held == win_n) begin
                        r_sum <= alu_y;
                    end else begin
                        r_held <= r_held + 1'b1;
                    end
                end
                S_ADD: begin
                    r_sum <= alu_y;
                    r_wp  <= (wp_inc >= win_n) ? '0 : wp_inc[IDX_W-1:0];
                end
                S_DIV: begin
                    if (div_done) begin
                        r_avg <= div_q[SAMPLE_BITS-1:0];
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out.average      <= r_avg;
                        r_out.samples_held <= SIZE_W'(r_held);
                    end
                end
                default: begin
                end
            endcase

            if (i_cfg_wr_en) begin
                r_size <= i_cfg_wr_data;
                r_wp   <= '0;
                r_held <= '0;
                r_sum  <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
